/* sv/ipwl_pkg.sv */
package ipwl_pkg;

  // Default table geometry.
  localparam int NumSensorsDef = 4;
  localparam int NumPointsDef  = 21;

  // Field widths.
  localparam int FuncW    = 1;
  localparam int SensorW  = 2;
  localparam int PidxW    = 5;
  localparam int SampleW  = 16;
  localparam int StepW    = 13;
  localparam int SegW     = 5;
  localparam int StatusW  = 3;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 16;

  // Divider geometry: the dividend is |reading - entry| times the step.
  localparam int DenW  = SampleW;
  localparam int NumW  = SampleW + StepW;
  localparam int CntW  = $clog2(NumW);
  localparam int WideW = 32;

  // Register reset values.
  localparam logic signed [SampleW-1:0] OriginRst = -16'sd5000;
  localparam logic [StepW-1:0]          StepRst   = 13'd500;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] CfgOrigin = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgStep   = 1'd1;

  // Input function codes.
  localparam logic [FuncW-1:0] FuncLoad    = 1'b0;
  localparam logic [FuncW-1:0] FuncConvert = 1'b1;

  // Result status codes.
  localparam logic [StatusW-1:0] StatInterp = 3'd0;
  localparam logic [StatusW-1:0] StatAbove  = 3'd1;
  localparam logic [StatusW-1:0] StatBelow  = 3'd2;
  localparam logic [StatusW-1:0] StatFlat   = 3'd3;
  localparam logic [StatusW-1:0] StatNoSeg  = 3'd4;

  // Saturation limits.
  localparam logic signed [WideW-1:0] DistMax = 32'sd32767;
  localparam logic signed [WideW-1:0] DistMin = -32'sd32768;

  typedef struct packed {
    logic wr;
    logic capture;
    logic scan;
    logic sel;
    logic mul;
    logic div;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic sensor_ok;
    logic scan_last;
    logic div_last;
  } sts_t;

endpackage

/* sv/ipwl_ram.sv */
module ipwl_ram #(
  parameter int Width = 16,
  parameter int Depth = 84
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/ipwl_ctrl.sv */
module ipwl_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [ipwl_pkg::FuncW-1:0]  func_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output ipwl_pkg::cmd_t              cmd_o,
  input  ipwl_pkg::sts_t              sts_i
);
  import ipwl_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    SCAN,
    SEL,
    MUL,
    DIV,
    FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (func_i == FuncLoad) begin
            cmd_o.wr = 1'b1;
          end else begin
            cmd_o.capture = 1'b1;
            // A request for a sensor without a table skips the search.
            state_d = sts_i.sensor_ok ? SCAN : FIN;
          end
        end
      end
      SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = SEL;
        end
      end
      SEL: begin
        cmd_o.sel = 1'b1;
        state_d   = MUL;
      end
      MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = DIV;
      end
      DIV: begin
        cmd_o.div = 1'b1;
        if (sts_i.div_last) begin
          state_d = FIN;
        end
      end
      FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = IDLE;
        end
      end
      default: begin
        state_d = IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* sv/ipwl_dp.sv */
module ipwl_dp #(
  parameter int NUM_SENSORS = ipwl_pkg::NumSensorsDef,
  parameter int NUM_POINTS  = ipwl_pkg::NumPointsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ipwl_pkg::cmd_t                       cmd_i,
  output ipwl_pkg::sts_t                       sts_o,
  input  logic [ipwl_pkg::SensorW-1:0]         sensor_i,
  input  logic [ipwl_pkg::PidxW-1:0]           point_index_i,
  input  logic signed [ipwl_pkg::SampleW-1:0]  sample_i,
  input  logic                                 cfg_we_i,
  input  logic [ipwl_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [ipwl_pkg::CfgDataW-1:0]        cfg_data_i,
  output logic signed [ipwl_pkg::SampleW-1:0]  distance_o,
  output logic [ipwl_pkg::SegW-1:0]            segment_o,
  output logic [ipwl_pkg::StatusW-1:0]         status_o,
  output logic                                 saturated_o
);
  import ipwl_pkg::*;

  localparam int Depth = NUM_SENSORS * NUM_POINTS;
  localparam int AW    = $clog2(Depth);
  localparam int PW    = $clog2(NUM_POINTS + 1);
  localparam int DW    = SampleW + 1;

  // Configuration registers.
  logic signed [SampleW-1:0] origin_q;
  logic [StepW-1:0]          step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= OriginRst;
      step_q   <= StepRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgOrigin: origin_q <= $signed(cfg_data_i);
        CfgStep:   step_q   <= cfg_data_i[StepW-1:0];
        default:   ;
      endcase
    end
  end

  // Table memory.
  logic          sensor_ok, pidx_ok;
  logic          ram_we, ram_re;
  logic [AW-1:0] waddr, raddr, base_q;
  logic [PW-1:0] idx_q;
  logic [SampleW-1:0] rdata;
  logic signed [SampleW-1:0] rd;

  assign sensor_ok = 32'(sensor_i) < 32'(NUM_SENSORS);
  assign pidx_ok   = 32'(point_index_i) < 32'(NUM_POINTS);
  assign ram_we    = cmd_i.wr && sensor_ok && pidx_ok;
  assign waddr     = AW'(32'(sensor_i) * 32'(NUM_POINTS) + 32'(point_index_i));
  assign ram_re    = cmd_i.scan && (32'(idx_q) < 32'(NUM_POINTS));
  assign raddr     = AW'(32'(base_q) + 32'(idx_q));
  assign rd        = $signed(rdata);

  ipwl_ram #(
    .Width(SampleW),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr),
    .wdata_i(sample_i),
    .re_i   (ram_re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Table scan. Read data for entry idx_q-1 arrives while entry idx_q is read.
  logic signed [SampleW-1:0] v_q, t0_q, t1_q, last_q, pen_q, lo_q, hi_q;
  logic [PW-1:0] fseg_q;
  logic          found_q, nosens_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      v_q      <= sample_i;
      base_q   <= AW'(32'(sensor_i) * 32'(NUM_POINTS));
      idx_q    <= '0;
      found_q  <= 1'b0;
      nosens_q <= !sensor_ok;
    end else if (cmd_i.scan) begin
      idx_q <= idx_q + PW'(1);
      if (idx_q != '0) begin
        last_q <= rd;
        pen_q  <= last_q;
        if (idx_q == PW'(1)) begin
          t0_q <= rd;
        end
        if (idx_q == PW'(2)) begin
          t1_q <= rd;
        end
        // The first segment in index order that holds the reading wins.
        if (idx_q > PW'(1) && !found_q && v_q >= last_q && v_q < rd) begin
          found_q <= 1'b1;
          lo_q    <= last_q;
          hi_q    <= rd;
          fseg_q  <= idx_q - PW'(2);
        end
      end
    end
  end

  assign sts_o.sensor_ok = sensor_ok;
  assign sts_o.scan_last = idx_q == PW'(NUM_POINTS);

  // Segment selection.
  logic signed [SampleW-1:0] s_base;
  logic signed [DW-1:0]      s_den, s_diff;
  logic [PW-1:0]             s_k, s_seg;
  logic [StatusW-1:0]        s_status;
  logic                      s_sub, above, below;

  always_comb begin
    above    = v_q >= last_q;
    below    = v_q < t0_q;
    s_base   = lo_q;
    s_den    = {hi_q[SampleW-1], hi_q} - {lo_q[SampleW-1], lo_q};
    s_k      = fseg_q;
    s_seg    = fseg_q;
    s_sub    = 1'b0;
    s_status = StatInterp;
    if (above) begin
      s_base   = last_q;
      s_den    = {last_q[SampleW-1], last_q} - {pen_q[SampleW-1], pen_q};
      s_k      = PW'(NUM_POINTS - 1);
      s_seg    = PW'(NUM_POINTS - 2);
      s_status = (s_den == '0) ? StatFlat : StatAbove;
    end else if (below) begin
      s_base   = t0_q;
      s_den    = {t0_q[SampleW-1], t0_q} - {t1_q[SampleW-1], t1_q};
      s_k      = '0;
      s_seg    = '0;
      s_sub    = 1'b1;
      s_status = (s_den == '0) ? StatFlat : StatBelow;
    end else if (!found_q) begin
      s_seg    = '0;
      s_status = StatNoSeg;
    end
    s_diff = {v_q[SampleW-1], v_q} - {s_base[SampleW-1], s_base};
  end

  logic [SampleW-1:0]  diff_mag_q;
  logic [DenW-1:0]     den_q;
  logic [PW-1:0]       k_q, seg_q;
  logic [StatusW-1:0]  status_q;
  logic                qneg_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sel) begin
      diff_mag_q <= SampleW'(s_diff[DW-1] ? -s_diff : s_diff);
      den_q      <= DenW'(s_den[DW-1] ? -s_den : s_den);
      qneg_q     <= s_diff[DW-1] ^ s_den[DW-1] ^ s_sub;
      k_q        <= s_k;
      seg_q      <= s_seg;
      status_q   <= s_status;
    end
  end

  // Product, calibration point and restoring divider.
  logic signed [WideW-1:0] p_q;
  logic [NumW-1:0]         quo_q;
  logic [DenW-1:0]         rem_q;
  logic [CntW-1:0]         cnt_q;
  logic [DenW:0]           trial;

  assign trial = {rem_q, quo_q[NumW-1]} - {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      quo_q <= NumW'(diff_mag_q) * NumW'(step_q);
      p_q   <= WideW'(origin_q) + $signed(WideW'(step_q) * WideW'(k_q));
      rem_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div) begin
      cnt_q <= cnt_q + CntW'(1);
      if (!trial[DenW]) begin
        rem_q <= trial[DenW-1:0];
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[DenW-2:0], quo_q[NumW-1]};
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end
  end

  assign sts_o.div_last = cnt_q == CntW'(NumW - 1);

  // Result assembly and output register.
  logic signed [WideW-1:0] q_mag, q_s, sum;
  logic                    no_seg;

  always_comb begin
    q_mag  = $signed(WideW'(quo_q));
    q_s    = qneg_q ? -q_mag : q_mag;
    sum    = (status_q == StatFlat) ? p_q : p_q + q_s;
    no_seg = nosens_q || (status_q == StatNoSeg);
  end

  logic signed [SampleW-1:0] dist_q;
  logic [SegW-1:0]           segment_q;
  logic [StatusW-1:0]        status_out_q;
  logic                      sat_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (no_seg) begin
        dist_q       <= '0;
        segment_q    <= '0;
        status_out_q <= StatNoSeg;
        sat_q        <= 1'b0;
      end else begin
        segment_q    <= SegW'(seg_q);
        status_out_q <= status_q;
        if (sum > DistMax) begin
          dist_q <= SampleW'(DistMax);
          sat_q  <= 1'b1;
        end else if (sum < DistMin) begin
          dist_q <= SampleW'(DistMin);
          sat_q  <= 1'b1;
        end else begin
          dist_q <= SampleW'(sum);
          sat_q  <= 1'b0;
        end
      end
    end
  end

  assign distance_o  = dist_q;
  assign segment_o   = segment_q;
  assign status_o    = status_out_q;
  assign saturated_o = sat_q;

endmodule

/* sv/inverse_piecewise_linear_calibration_top.sv */
// Inverse piecewise-linear calibration. Each sensor has a table of NUM_POINTS
// raw readings taken at evenly spaced output points (origin plus i times step).
// Requests arrive on a valid/ready input channel. A load request (func 0)
// writes one table entry in the cycle it is accepted and gives no result.
// A convert request (func 1) scans the sensor's table once, one entry per
// cycle from the table RAM, then multiplies and runs a bit-serial divider of
// 29 steps before its result is loaded into the output register; a request
// for a sensor without a table skips the scan and the divider.
// One request is in work at a time: no new request is accepted until the
// current one has loaded its result.
// Results leave through an output register on a valid/ready channel. While
// the receiver stalls, the block still accepts the next request and finishes
// its work, then holds it until the output register frees up.
// Reset clears the control state and sets the origin to -5000 and the step to
// 500; table contents are undefined until loaded. Configuration writes take
// effect at once and must only be made while the block is idle.
module inverse_piecewise_linear_calibration_top #(
  parameter int NUM_SENSORS = ipwl_pkg::NumSensorsDef,
  parameter int NUM_POINTS  = ipwl_pkg::NumPointsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [ipwl_pkg::FuncW-1:0]           func_i,
  input  logic [ipwl_pkg::SensorW-1:0]         sensor_i,
  input  logic [ipwl_pkg::PidxW-1:0]           point_index_i,
  input  logic signed [ipwl_pkg::SampleW-1:0]  sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [ipwl_pkg::SampleW-1:0]  distance_o,
  output logic [ipwl_pkg::SegW-1:0]            segment_o,
  output logic [ipwl_pkg::StatusW-1:0]         status_o,
  output logic                                 saturated_o,
  input  logic                                 cfg_we_i,
  input  logic [ipwl_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [ipwl_pkg::CfgDataW-1:0]        cfg_data_i
);
  import ipwl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ipwl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  ipwl_dp #(
    .NUM_SENSORS(NUM_SENSORS),
    .NUM_POINTS (NUM_POINTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .sensor_i     (sensor_i),
    .point_index_i(point_index_i),
    .sample_i     (sample_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .distance_o   (distance_o),
    .segment_o    (segment_o),
    .status_o     (status_o),
    .saturated_o  (saturated_o)
  );

endmodule
